[rtl/iol_pkg.sv]
package iol_pkg;

    localparam int CAPACITY_DEFAULT = 1024;

    localparam int DATA_W = 32;
    localparam int TYPE_W = 3;
    localparam int POS_W  = 12;
    localparam int LEN_W  = 11;

    typedef enum logic [TYPE_W-1:0] {
        REQ_READ = 3'd0,
        REQ_HEAD = 3'd1,
        REQ_TAIL = 3'd2,
        REQ_AT   = 3'd3,
        REQ_DEL  = 3'd4
    } req_kind_t;

    // Operation broadcast to every cell of the row.
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_SCAN = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                op;
        logic [DATA_W-1:0]       value;
    } cell_ctl_t;

endpackage

[rtl/iol_req_if.sv]
interface iol_req_if;
    logic                                valid;
    logic                                ready;
    logic [iol_pkg::TYPE_W-1:0]          req_type;
    logic signed [iol_pkg::POS_W-1:0]    position;
    logic signed [iol_pkg::DATA_W-1:0]   item_value;

    modport source (output valid, req_type, position, item_value, input ready);
    modport sink   (input valid, req_type, position, item_value, output ready);
endinterface

[rtl/iol_rsp_if.sv]
interface iol_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [iol_pkg::DATA_W-1:0]   read_value;
    logic                                read_hit;
    logic                                applied;
    logic                                full_refused;
    logic [iol_pkg::LEN_W-1:0]           list_length;

    modport source (output valid, read_value, read_hit, applied, full_refused, list_length,
                    input ready);
    modport sink   (input valid, read_value, read_hit, applied, full_refused, list_length,
                    output ready);
endinterface

[rtl/iol_cell.sv]
module iol_cell #(
    parameter int IW  = 10,
    parameter int IDX = 0
) (
    input  logic                         clk,
    input  iol_pkg::cell_ctl_t           ctl,
    input  logic [IW-1:0]                pos,
    input  logic [iol_pkg::DATA_W-1:0]   left_value,
    input  logic [iol_pkg::DATA_W-1:0]   right_value,
    input  logic [iol_pkg::DATA_W-1:0]   right_carry,
    output logic [iol_pkg::DATA_W-1:0]   value,
    output logic [iol_pkg::DATA_W-1:0]   carry
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [iol_pkg::DATA_W-1:0] value_reg;
    logic [iol_pkg::DATA_W-1:0] value_next;
    logic [iol_pkg::DATA_W-1:0] carry_reg;
    logic [iol_pkg::DATA_W-1:0] carry_next;

    always_comb
    begin
        value_next = value_reg;
        carry_next = carry_reg;
        case (ctl.op)
            iol_pkg::CELL_INS:
            begin
                if (MY_IDX > pos)
                begin
                    value_next = left_value;
                end
                else if (MY_IDX == pos)
                begin
                    value_next = ctl.value;
                end
            end
            iol_pkg::CELL_DEL:
            begin
                if (MY_IDX >= pos)
                begin
                    value_next = right_value;
                end
            end
            iol_pkg::CELL_SCAN:
            begin
                // The selected cell launches its value; all others pass it toward the head.
                carry_next = (MY_IDX == pos) ? value_reg : right_carry;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        carry_reg <= carry_next;
    end

    assign value = value_reg;
    assign carry = carry_reg;

endmodule

[rtl/iol_chain.sv]
module iol_chain #(
    parameter int CAPACITY = iol_pkg::CAPACITY_DEFAULT,
    parameter int IW       = $clog2(CAPACITY)
) (
    input  logic                         clk,
    input  iol_pkg::cell_ctl_t           ctl,
    input  logic [IW-1:0]                pos,
    output logic [iol_pkg::DATA_W-1:0]   head_carry
);

    logic [iol_pkg::DATA_W-1:0] cell_value [CAPACITY];
    logic [iol_pkg::DATA_W-1:0] cell_carry [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [iol_pkg::DATA_W-1:0] left_v;
        logic [iol_pkg::DATA_W-1:0] right_v;
        logic [iol_pkg::DATA_W-1:0] right_c;

        if (i == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_inner_l
            assign left_v = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_v = '0;
            assign right_c = '0;
        end
        else
        begin : g_inner_r
            assign right_v = cell_value[i+1];
            assign right_c = cell_carry[i+1];
        end

        iol_cell #(
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .pos         (pos),
            .left_value  (left_v),
            .right_value (right_v),
            .right_carry (right_c),
            .value       (cell_value[i]),
            .carry       (cell_carry[i])
        );
    end

    assign head_carry = cell_carry[0];

endmodule

[rtl/indexed_ordered_list_unit.sv]
// Channel  Modport  Payload                                    Direction
// req      sink     req_type, position, item_value             into the block
// rsp      source   read_value, read_hit, applied,             out of the block
//                   full_refused, list_length
//
// An accepted insert or delete shifts the row of cells at the edge that accepts the request;
// a missed read, a dropped or refused insert and an unused request code leave it unchanged.
// A read that hits runs the result chain, which walks the selected value one cell per
// cycle toward cell 0.
// Reset clears the element count and the control state only; cell contents stay
// undefined and are never read before they are written, so there is no clearing pass.
// A request is accepted while the previous result still waits in the output register;
// when that register stays stalled, the new result is held and no further request is
// taken until it moves on.
module indexed_ordered_list_unit #(
    parameter int CAPACITY = iol_pkg::CAPACITY_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    iol_req_if.sink   req,
    iol_rsp_if.source rsp
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    // Width wide enough for both the count and the non-negative part of a position.
    localparam int PW = (CW > iol_pkg::LEN_W) ? CW : iol_pkg::LEN_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [IW-1:0]                scan_pos_reg;
    logic [IW-1:0]                scan_pos_next;
    logic [IW-1:0]                scan_cnt_reg;
    logic [IW-1:0]                scan_cnt_next;

    // Result waiting for the output register.
    logic                         pend_hit_reg;
    logic                         pend_hit_next;
    logic                         pend_applied_reg;
    logic                         pend_applied_next;
    logic                         pend_refused_reg;
    logic                         pend_refused_next;

    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;
    logic [iol_pkg::DATA_W-1:0]   rsp_value_reg;
    logic [iol_pkg::DATA_W-1:0]   rsp_value_next;
    logic                         rsp_hit_reg;
    logic                         rsp_hit_next;
    logic                         rsp_applied_reg;
    logic                         rsp_applied_next;
    logic                         rsp_refused_reg;
    logic                         rsp_refused_next;
    logic [iol_pkg::LEN_W-1:0]    rsp_len_reg;
    logic [iol_pkg::LEN_W-1:0]    rsp_len_next;

    logic                         accept;
    logic                         out_free;
    logic                         pos_neg;
    logic [PW-1:0]                pos_u;
    logic [PW-1:0]                cnt_ext;
    logic [PW-1:0]                cnt_after;
    logic [PW-1:0]                ins_pos;
    logic                         in_range;
    logic                         is_read;
    logic                         is_ins;
    logic                         is_del;
    logic                         ins_valid;
    logic                         full;
    logic                         rd_hit;
    logic                         ins_ok;
    logic                         ins_refused;
    logic                         del_ok;

    iol_pkg::cell_ctl_t           ctl;
    logic [IW-1:0]                ctl_pos;
    logic [iol_pkg::DATA_W-1:0]   head_carry;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    // Request decode. A negative position has its sign bit set; otherwise the low bits
    // are the position itself.
    always_comb
    begin
        pos_neg   = req.position[iol_pkg::POS_W-1];
        pos_u     = PW'(req.position[iol_pkg::POS_W-2:0]);
        cnt_ext   = PW'(count_reg);
        in_range  = !pos_neg && (pos_u < cnt_ext);
        full      = (count_reg == CW'(CAPACITY));

        is_read   = (req.req_type == iol_pkg::REQ_READ);
        is_del    = (req.req_type == iol_pkg::REQ_DEL);
        is_ins    = (req.req_type == iol_pkg::REQ_HEAD) ||
                    (req.req_type == iol_pkg::REQ_TAIL) ||
                    (req.req_type == iol_pkg::REQ_AT);

        ins_pos   = '0;
        ins_valid = 1'b1;
        if (req.req_type == iol_pkg::REQ_TAIL)
        begin
            ins_pos = cnt_ext;
        end
        else if ((req.req_type == iol_pkg::REQ_AT) && !pos_neg)
        begin
            ins_pos   = pos_u;
            // An insert beyond the length is dropped before the full check applies.
            ins_valid = (pos_u <= cnt_ext);
        end

        rd_hit      = is_read && in_range;
        ins_ok      = is_ins && ins_valid && !full;
        ins_refused = is_ins && ins_valid && full;
        del_ok      = is_del && in_range;

        cnt_after = cnt_ext;
        if (ins_ok)
        begin
            cnt_after = cnt_ext + PW'(1);
        end
        else if (del_ok)
        begin
            cnt_after = cnt_ext - PW'(1);
        end
    end

    // Broadcast to the row of cells.
    always_comb
    begin
        ctl.op    = iol_pkg::CELL_HOLD;
        ctl.value = req.item_value;
        ctl_pos   = pos_u[IW-1:0];
        if (state_reg == ST_SCAN)
        begin
            ctl.op  = iol_pkg::CELL_SCAN;
            ctl_pos = scan_pos_reg;
        end
        else if (accept && ins_ok)
        begin
            ctl.op  = iol_pkg::CELL_INS;
            ctl_pos = ins_pos[IW-1:0];
        end
        else if (accept && del_ok)
        begin
            ctl.op = iol_pkg::CELL_DEL;
        end
    end

    iol_chain #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_chain (
        .clk        (clk),
        .ctl        (ctl),
        .pos        (ctl_pos),
        .head_carry (head_carry)
    );

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        scan_pos_next     = scan_pos_reg;
        scan_cnt_next     = scan_cnt_reg;
        pend_hit_next     = pend_hit_reg;
        pend_applied_next = pend_applied_reg;
        pend_refused_next = pend_refused_reg;

        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        rsp_value_next    = rsp_value_reg;
        rsp_hit_next      = rsp_hit_reg;
        rsp_applied_next  = rsp_applied_reg;
        rsp_refused_next  = rsp_refused_reg;
        rsp_len_next      = rsp_len_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = cnt_after[CW-1:0];
                    if (rd_hit)
                    begin
                        scan_pos_next     = pos_u[IW-1:0];
                        scan_cnt_next     = pos_u[IW-1:0];
                        pend_hit_next     = 1'b1;
                        pend_applied_next = 1'b1;
                        pend_refused_next = 1'b0;
                        state_next        = ST_SCAN;
                    end
                    else if (out_free)
                    begin
                        rsp_valid_next   = 1'b1;
                        rsp_value_next   = '1;
                        rsp_hit_next     = 1'b0;
                        rsp_applied_next = ins_ok || del_ok;
                        rsp_refused_next = ins_refused;
                        rsp_len_next     = cnt_after[iol_pkg::LEN_W-1:0];
                    end
                    else
                    begin
                        pend_hit_next     = 1'b0;
                        pend_applied_next = ins_ok || del_ok;
                        pend_refused_next = ins_refused;
                        state_next        = ST_HOLD;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == '0)
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg - IW'(1);
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_value_next   = pend_hit_reg ? head_carry : '1;
                    rsp_hit_next     = pend_hit_reg;
                    rsp_applied_next = pend_applied_reg;
                    rsp_refused_next = pend_refused_reg;
                    rsp_len_next     = cnt_ext[iol_pkg::LEN_W-1:0];
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_pos_reg     <= scan_pos_next;
        scan_cnt_reg     <= scan_cnt_next;
        pend_hit_reg     <= pend_hit_next;
        pend_applied_reg <= pend_applied_next;
        pend_refused_reg <= pend_refused_next;
        rsp_value_reg    <= rsp_value_next;
        rsp_hit_reg      <= rsp_hit_next;
        rsp_applied_reg  <= rsp_applied_next;
        rsp_refused_reg  <= rsp_refused_next;
        rsp_len_reg      <= rsp_len_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.read_value   = rsp_value_reg;
    assign rsp.read_hit     = rsp_hit_reg;
    assign rsp.applied      = rsp_applied_reg;
    assign rsp.full_refused = rsp_refused_reg;
    assign rsp.list_length  = rsp_len_reg;

    // The element count never passes the capacity of the row.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    // A successful insert grows the list by exactly one element.
    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ins_ok |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the list by one");

    // A refused insert leaves the list as it was.
    a_refused_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ins_refused |=> count_reg == $past(count_reg))
        else $error("refused insert changed the list");

    // The scan ends when its countdown reaches zero.
    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && scan_cnt_reg == '0 |=> state_reg == ST_HOLD)
        else $error("read scan did not end on time");

    // A hit is always reported as applied and never as refused.
    a_hit_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_hit_reg |-> rsp_applied_reg && !rsp_refused_reg)
        else $error("inconsistent flags on a read hit");

endmodule
